@@ hw/rtl/tnrx_pkg.sv @@
package tnrx_pkg;

    // Telnet command bytes
    localparam logic [7:0] TN_IAC  = 8'd255;
    localparam logic [7:0] TN_DONT = 8'd254;
    localparam logic [7:0] TN_DO   = 8'd253;
    localparam logic [7:0] TN_WONT = 8'd252;
    localparam logic [7:0] TN_WILL = 8'd251;
    localparam logic [7:0] TN_SB   = 8'd250;
    localparam logic [7:0] TN_SEND = 8'd1;

    // Result kinds
    localparam logic [1:0] KIND_DATA     = 2'd0;
    localparam logic [1:0] KIND_NEGOTIATE = 2'd1;
    localparam logic [1:0] KIND_SB_SEND  = 2'd2;
    localparam logic [1:0] KIND_UNUSED   = 2'd3;

    // Register map
    localparam int unsigned PADDR_W  = 3;
    localparam int unsigned PDATA_W  = 32;
    localparam logic [PADDR_W-1:0] ADDR_RAW_PASSTHROUGH = 3'd0;

    typedef enum logic [6:0] {
        ST_NORMAL  = 7'b0000001,
        ST_GOT_IAC = 7'b0000010,
        ST_VERB    = 7'b0000100,
        ST_SB_OPT  = 7'b0001000,
        ST_SB_QUAL = 7'b0010000,
        ST_SB_SEND = 7'b0100000,
        ST_SB_IAC  = 7'b1000000
    } parse_state_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [1:0] verb;
        logic [7:0] option;
    } result_t;

endpackage

@@ hw/rtl/telnet_receive_command_parser.sv @@
// Telnet receive command parser. Each accepted item is one byte from the
// network; the block splits telnet commands from terminal data and emits at
// most one result item per byte: kind 0 is a data byte for the terminal
// (including the 255 produced by IAC IAC), kind 1 is an option negotiation
// (IAC WILL/WONT/DO/DONT opt, verb 0..3 in that order), kind 2 is a
// subnegotiation send request (IAC SB opt SEND IAC x). Any other command
// after IAC is swallowed. With raw_passthrough set (APB register at byte
// address 0, bit 0) every byte passes through as data and the parser state
// is frozen, so parsing resumes where it stopped once raw mode is cleared.
// Rate: one byte per clock while in_stall is low. The parser state and the
// result are computed in the accept cycle; the result is registered in the
// output register, or in the one-entry skid register behind it while the
// output item is held. The skid register lets the input side keep accepting
// while a result waits; in_stall rises only when both registers hold results.
module telnet_receive_command_parser
    import tnrx_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    // APB configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,

    // Received byte channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,

    // Result channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         kind,
    output logic [7:0]         data_byte,
    output logic [1:0]         verb,
    output logic [7:0]         option
);

    logic         raw_reg;
    parse_state_t state_reg, state_next;
    logic [1:0]   saved_verb_reg, saved_verb_next;
    logic [7:0]   saved_option_reg, saved_option_next;

    logic         out_valid_reg;
    result_t      out_reg;
    logic         skid_valid_reg;
    result_t      skid_reg;

    logic         in_accept;
    logic         res_valid;
    result_t      res;
    logic         out_free;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_RAW_PASSTHROUGH) ? {{(PDATA_W-1){1'b0}}, raw_reg}
                                                   : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && (paddr == ADDR_RAW_PASSTHROUGH))
        begin
            raw_reg <= pwdata[0];
        end
    end

    // ------------------------------------------------------------------
    // Parser: next state and result for the byte being accepted
    // ------------------------------------------------------------------
    // Hold input only while both result slots are full.
    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;

    always_comb
    begin
        state_next        = state_reg;
        saved_verb_next   = saved_verb_reg;
        saved_option_next = saved_option_reg;
        res_valid         = 1'b0;
        res               = '{kind: KIND_DATA, data_byte: 8'd0, verb: 2'd0, option: 8'd0};

        if (raw_reg)
        begin
            // Pass the byte through; leave the parser where it is.
            res_valid     = 1'b1;
            res.data_byte = rx_byte;
        end
        else
        begin
            unique case (state_reg)
                ST_GOT_IAC:
                begin
                    if (rx_byte >= TN_WILL && rx_byte <= TN_DONT)
                    begin
                        saved_verb_next = 2'(rx_byte - TN_WILL);
                        state_next      = ST_VERB;
                    end
                    else if (rx_byte == TN_IAC)
                    begin
                        // Escaped 255 goes to the terminal.
                        state_next    = ST_NORMAL;
                        res_valid     = 1'b1;
                        res.data_byte = TN_IAC;
                    end
                    else if (rx_byte == TN_SB)
                    begin
                        state_next = ST_SB_OPT;
                    end
                    else
                    begin
                        // Drop any other command.
                        state_next = ST_NORMAL;
                    end
                end
                ST_VERB:
                begin
                    state_next = ST_NORMAL;
                    res_valid  = 1'b1;
                    res.kind   = KIND_NEGOTIATE;
                    res.verb   = saved_verb_reg;
                    res.option = rx_byte;
                end
                ST_SB_OPT:
                begin
                    saved_option_next = rx_byte;
                    state_next        = ST_SB_QUAL;
                end
                ST_SB_QUAL:
                begin
                    state_next = (rx_byte == TN_SEND) ? ST_SB_SEND : ST_NORMAL;
                end
                ST_SB_SEND:
                begin
                    state_next = (rx_byte == TN_IAC) ? ST_SB_IAC : ST_NORMAL;
                end
                ST_SB_IAC:
                begin
                    // Any byte closes the request; SE is not checked.
                    state_next = ST_NORMAL;
                    res_valid  = 1'b1;
                    res.kind   = KIND_SB_SEND;
                    res.option = saved_option_reg;
                end
                default:
                begin
                    if (rx_byte == TN_IAC)
                    begin
                        state_next = ST_GOT_IAC;
                    end
                    else
                    begin
                        state_next    = ST_NORMAL;
                        res_valid     = 1'b1;
                        res.data_byte = rx_byte;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_NORMAL;
            saved_verb_reg   <= 2'd0;
            saved_option_reg <= 8'd0;
        end
        else if (in_accept)
        begin
            state_reg        <= state_next;
            saved_verb_reg   <= saved_verb_next;
            saved_option_reg <= saved_option_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register with skid slot
    // ------------------------------------------------------------------
    // The output slot frees up when it is empty or its item is taken now.
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                // Advance the waiting item; no new item is taken this cycle.
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_accept && res_valid;
            end
        end
        else if (in_accept && res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end
        if (!out_free && in_accept && res_valid)
        begin
            skid_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = out_reg.kind;
    assign data_byte = out_reg.data_byte;
    assign verb      = out_reg.verb;
    assign option    = out_reg.option;

`ifndef SYNTH
    // The skid slot only fills behind a held output item.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot full while output register empty");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("parser state lost its one-hot code");

    // Raw mode yields a result for every accepted byte.
    a_raw_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && raw_reg) |=> out_valid_reg)
        else $error("raw byte produced no result");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.kind != KIND_UNUSED))
        else $error("result carries an unused kind code");

    // A state change only happens on an accepted byte.
    a_state_moves_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !in_accept |=> $stable(state_reg))
        else $error("parser state moved without an accepted item");
`endif

endmodule

@@ test/telnet_receive_command_parser_tb.sv @@
module telnet_receive_command_parser_tb;
    import tnrx_pkg::*;

    // Address 4 of the register map: nothing lives there, so writes must vanish.
    localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = 3'd4;
    // Output register plus skid entry; settle time after the last result.
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_LIMIT   = 2000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;

    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         rx_byte = 8'h00;

    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         kind;
    logic [7:0]         data_byte;
    logic [1:0]         verb;
    logic [7:0]         option;

    // Bytes waiting to be offered, and parser results still owed by the block.
    logic [7:0]         pending_rx_bytes[$];
    result_t            expected_parser_results[$];

    // Shadow of the parser: raw mode, sequence position, held verb and option.
    logic               raw_mode = 1'b0;
    parse_state_t       telnet_state = ST_NORMAL;
    logic [1:0]         held_verb = 2'd0;
    logic [7:0]         held_option = 8'h00;

    int                 sender_idle_pct = 0;
    int                 receiver_stall_pct = 0;
    int                 fail_count = 0;

    telnet_receive_command_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .data_byte (data_byte),
        .verb      (verb),
        .option    (option)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    // Advance the shadow parser by one received byte; queue the result it owes.
    task automatic parse_received_byte(input logic [7:0] b);
        result_t r;
        bit      emit;
        r    = '0;
        emit = 1'b0;
        if (raw_mode)
        begin
            // Raw mode: pass the byte, leave the sequence position frozen.
            r.kind      = KIND_DATA;
            r.data_byte = b;
            emit        = 1'b1;
        end
        else
        begin
            case (telnet_state)
                ST_GOT_IAC:
                    if (b >= TN_WILL && b <= TN_DONT)
                    begin
                        held_verb    = 2'(b - TN_WILL);
                        telnet_state = ST_VERB;
                    end
                    else if (b == TN_IAC)
                    begin
                        // Escaped 255 goes to the terminal.
                        telnet_state = ST_NORMAL;
                        r.kind       = KIND_DATA;
                        r.data_byte  = TN_IAC;
                        emit         = 1'b1;
                    end
                    else if (b == TN_SB)
                        telnet_state = ST_SB_OPT;
                    else
                        telnet_state = ST_NORMAL;   // drop unknown command
                ST_VERB:
                begin
                    telnet_state = ST_NORMAL;
                    r.kind       = KIND_NEGOTIATE;
                    r.verb       = held_verb;
                    r.option     = b;
                    emit         = 1'b1;
                end
                ST_SB_OPT:
                begin
                    held_option  = b;
                    telnet_state = ST_SB_QUAL;
                end
                ST_SB_QUAL:
                    if (b == TN_SEND)
                        telnet_state = ST_SB_SEND;
                    else
                        telnet_state = ST_NORMAL;
                ST_SB_SEND:
                    if (b == TN_IAC)
                        telnet_state = ST_SB_IAC;
                    else
                        telnet_state = ST_NORMAL;
                ST_SB_IAC:
                begin
                    // Any closing byte completes the request, SE or not.
                    telnet_state = ST_NORMAL;
                    r.kind       = KIND_SB_SEND;
                    r.option     = held_option;
                    emit         = 1'b1;
                end
                default:
                    if (b == TN_IAC)
                        telnet_state = ST_GOT_IAC;
                    else
                    begin
                        telnet_state = ST_NORMAL;
                        r.kind       = KIND_DATA;
                        r.data_byte  = b;
                        emit         = 1'b1;
                    end
            endcase
        end
        if (emit)
            expected_parser_results.push_back(r);
    endtask

    // Sender: offer the next queued byte unless idling; hold it while stalled.
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                parse_received_byte(rx_byte);
            if (!in_valid || !in_stall)
            begin
                if (pending_rx_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    in_valid <= 1'b1;
                    rx_byte  <= pending_rx_bytes.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall at random.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // Check every accepted result against the oldest expectation.
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_parser_results.size() == 0)
                note_failure($sformatf("unexpected result kind %0d data %02h verb %0d option %02h",
                                       kind, data_byte, verb, option));
            else
            begin
                want = expected_parser_results.pop_front();
                if (kind !== want.kind || data_byte !== want.data_byte ||
                    verb !== want.verb || option !== want.option)
                    note_failure($sformatf({"result mismatch: expected kind %0d data %02h ",
                                            "verb %0d option %02h, got kind %0d data %02h ",
                                            "verb %0d option %02h"},
                                           want.kind, want.data_byte, want.verb, want.option,
                                           kind, data_byte, verb, option));
            end
        end
    end

    // Write a register, then read back raw_passthrough to confirm its value.
    task automatic write_config(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == ADDR_RAW_PASSTHROUGH)
            raw_mode = value[0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_RAW_PASSTHROUGH;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== {{(PDATA_W-1){1'b0}}, raw_mode})
            note_failure($sformatf("raw_passthrough read back %08h, expected %0d",
                                   prdata, raw_mode));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Hold until every byte is taken and every owed result has come out.
    task automatic wait_until_drained();
        int waited;
        while (pending_rx_bytes.size() != 0 || in_valid)
            @(negedge clk);
        waited = 0;
        while (expected_parser_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (expected_parser_results.size() != 0)
        begin
            note_failure($sformatf("%0d results never arrived", expected_parser_results.size()));
            expected_parser_results.delete();
        end
        // Let a byte that owes nothing finish inside the block.
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        sender_idle_pct    = sender_pct;
        receiver_stall_pct = receiver_pct;
    endtask

    // Queue random telnet traffic: mostly well-formed commands, some noise.
    task automatic queue_random_items(input int n);
        int         added;
        int         pick;
        logic [7:0] opt;
        added = 0;
        while (added < n)
        begin
            pick = $urandom_range(99);
            opt  = 8'($urandom);
            if (pick < 30)
            begin
                pending_rx_bytes.push_back(8'($urandom_range(254)));
                added += 1;
            end
            else if (pick < 38)
            begin
                pending_rx_bytes = {pending_rx_bytes, TN_IAC, TN_IAC};
                added += 2;
            end
            else if (pick < 58)
            begin
                pending_rx_bytes = {pending_rx_bytes, TN_IAC,
                                    8'(TN_WILL + $urandom_range(3)), opt};
                added += 3;
            end
            else if (pick < 73)
            begin
                pending_rx_bytes = {pending_rx_bytes, TN_IAC, TN_SB, opt, TN_SEND,
                                    TN_IAC, 8'($urandom)};
                added += 6;
            end
            else if (pick < 79)
            begin
                // Subnegotiation with a random qualifier, usually not SEND.
                pending_rx_bytes = {pending_rx_bytes, TN_IAC, TN_SB, opt, 8'($urandom)};
                added += 4;
            end
            else if (pick < 84)
            begin
                // SEND followed by something other than IAC most of the time.
                pending_rx_bytes = {pending_rx_bytes, TN_IAC, TN_SB, opt, TN_SEND,
                                    8'($urandom)};
                added += 5;
            end
            else if (pick < 90)
            begin
                // Command that the parser only swallows.
                pending_rx_bytes = {pending_rx_bytes, TN_IAC, 8'($urandom_range(249))};
                added += 2;
            end
            else
            begin
                pending_rx_bytes.push_back(8'($urandom));
                added += 1;
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: data, escaped 255, all four verbs (options include 00 and FF),
        // a full SEND request, a non-SEND qualifier, SEND without IAC, an
        // unknown command, and data after it.
        set_idling(0, 0);
        pending_rx_bytes = {8'h00, TN_IAC, TN_IAC,
                            TN_IAC, TN_WILL, 8'h00, TN_IAC, TN_WONT, 8'hFF,
                            TN_IAC, TN_DO, 8'h18, TN_IAC, TN_DONT, TN_SEND,
                            TN_IAC, TN_SB, 8'h18, TN_SEND, TN_IAC, 8'hF0,
                            TN_IAC, TN_SB, 8'h05, 8'h00,
                            TN_IAC, TN_SB, 8'h07, TN_SEND, 8'h41,
                            TN_IAC, 8'hF1, 8'h7F};
        wait_until_drained();

        // Raw mode freezes a half-parsed subnegotiation; the unmapped write
        // must not touch raw mode; clearing raw mode resumes the request.
        pending_rx_bytes = {TN_IAC, TN_SB, 8'h22};
        wait_until_drained();
        write_config(ADDR_RAW_PASSTHROUGH, 32'hFFFF_FFFF);
        pending_rx_bytes = {TN_IAC, 8'h00, TN_SB};
        wait_until_drained();
        write_config(ADDR_UNMAPPED, 32'h0000_0000);
        pending_rx_bytes = {8'hFF};
        wait_until_drained();
        write_config(ADDR_RAW_PASSTHROUGH, 32'h0000_0000);
        pending_rx_bytes = {TN_SEND, TN_IAC, 8'h00};
        wait_until_drained();

        // Random traffic across the idling mixes.
        set_idling(0, 0);
        queue_random_items(100);
        wait_until_drained();
        set_idling(60, 0);
        queue_random_items(120);
        wait_until_drained();
        set_idling(0, 60);
        queue_random_items(60);
        // Pause the sender mid-phase until every owed result is out.
        wait_until_drained();
        queue_random_items(60);
        wait_until_drained();
        set_idling(22, 22);
        queue_random_items(120);
        wait_until_drained();

        write_config(ADDR_RAW_PASSTHROUGH, 32'h0000_0001);
        queue_random_items(60);
        wait_until_drained();
        write_config(ADDR_RAW_PASSTHROUGH, 32'h0000_0000);
        set_idling(60, 60);
        queue_random_items(60);
        wait_until_drained();

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #3000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/tnrx_pkg.sv
hw/rtl/telnet_receive_command_parser.sv
test/telnet_receive_command_parser_tb.sv
